// ===== rtl/crcr_pkg.sv =====
// Shared types, constants and the root-search step for the circle/rectangle
// collision block. No dependencies.
package crcr_pkg;

  localparam int PW = 54;        // width of the squared-product accumulators
  localparam int NSTEP = 13;     // bits searched for each contact offset
  localparam int RW = 12;        // radius width
  localparam logic [RW-1:0] RADIUS_RESET = 12'd128;

  typedef struct packed {
    logic [15:0]        bx;
    logic [15:0]        by;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               dx_neg;
    logic               dx_pos;
    logic               dy_neg;
    logic               dy_pos;
    logic               x_major;
    logic               hit;
    logic               zero;
    logic [RW-1:0]      r;
  } side_t;

  // p = (2n-1)^2 * d2, a = (2n-1) * d2, rhs = 4 * (r*|d|)^2
  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] rhs;
    logic [RW-1:0]        n;
  } lane_t;

  typedef struct packed {
    side_t       side;
    logic [23:0] d2;
    lane_t       lx;
    lane_t       ly;
  } iter_t;

  // Try setting bit b of n; keeps p and a current with shifts and adds only.
  function automatic lane_t lane_step(lane_t l, logic [23:0] d2, logic [RW-1:0] r,
                                      int b);
    lane_t                o;
    logic signed [PW-1:0] d2w;
    logic signed [PW-1:0] pt;
    logic [RW:0]          t;
    o   = l;
    d2w = PW'(d2);
    t   = {1'b0, l.n} | ((RW+1)'(1) << b);
    pt  = l.p + (l.a <<< (b + 2)) + (d2w <<< (2 * b + 2));
    if (t <= {1'b0, r} && pt <= l.rhs) begin
      o.n = t[RW-1:0];
      o.p = pt;
      o.a = l.a + (d2w <<< (b + 1));
    end
    return o;
  endfunction

endpackage

// ===== rtl/circle_rect_collision_reflect.sv =====
// Top level of the circle vs. rectangle collision and reflection block.
// Depends on crcr_pkg, crcr_front, crcr_root, crcr_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): ball centre and velocity plus one
//    axis-aligned rectangle per transfer. Result channel (out_valid/
//    out_ready): hit flag, contact point, axis normal, reflected velocity.
//  - cfg_wr_en/cfg_wr_data write the ball radius (Q12.0, reset 128). Write
//    it only while the pipe is empty.
//  - The pipe is 4 front stages (clamp, squares, distance test, search
//    setup), 13 stages of the offset root search (one result bit each,
//    both axes side by side) and 1 output register.
//  - Throughput is one transfer per cycle while the pipe is not stalled;
//    the 13-step search is fully pipelined, so nothing recirculates.
//  - The whole pipe advances together: when out_valid is high and
//    out_ready low, everything holds and in_ready drops. Nothing is lost or
//    repeated. Bubbles are not squeezed out during a stall.
//  - Synchronous active-low reset clears all valid bits and loads the
//    default radius.
module circle_rect_collision_reflect import crcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_ball_x,
  input  logic [15:0]        in_ball_y,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic [15:0]        in_rect_x,
  input  logic [15:0]        in_rect_y,
  input  logic [15:0]        in_rect_width,
  input  logic [15:0]        in_rect_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [15:0]        out_contact_x,
  output logic [15:0]        out_contact_y,
  output logic signed [1:0]  out_normal_x,
  output logic signed [1:0]  out_normal_y,
  output logic signed [15:0] out_new_vel_x,
  output logic signed [15:0] out_new_vel_y,
  input  logic               cfg_wr_en,
  input  logic [RW-1:0]      cfg_wr_data
);

  logic [RW-1:0] radius_r;
  logic          en;
  logic          fv, rv;
  iter_t         fd, rd;

  // Radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // Global advance: output slot free or being taken this cycle
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  crcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .ball_x      (in_ball_x),
    .ball_y      (in_ball_y),
    .vel_x       (in_vel_x),
    .vel_y       (in_vel_y),
    .rect_x      (in_rect_x),
    .rect_y      (in_rect_y),
    .rect_width  (in_rect_width),
    .rect_height (in_rect_height),
    .radius      (radius_r),
    .v_o         (fv),
    .d_o         (fd)
  );

  crcr_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (fv),
    .d_i   (fd),
    .v_o   (rv),
    .d_o   (rd)
  );

  crcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_i       (rv),
    .d_i       (rd),
    .out_valid (out_valid),
    .hit       (out_hit),
    .contact_x (out_contact_x),
    .contact_y (out_contact_y),
    .normal_x  (out_normal_x),
    .normal_y  (out_normal_y),
    .new_vel_x (out_new_vel_x),
    .new_vel_y (out_new_vel_y)
  );

endmodule

// ===== rtl/crcr_front.sv =====
// Front stages: clamp, squares, distance test, offset search setup.
// Depends on crcr_pkg.
module crcr_front import crcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        ball_x,
  input  logic [15:0]        ball_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic [15:0]        rect_x,
  input  logic [15:0]        rect_y,
  input  logic [15:0]        rect_width,
  input  logic [15:0]        rect_height,
  input  logic [RW-1:0]      radius,
  output logic               v_o,
  output iter_t              d_o
);

  // stage 1: closest point and |d|
  logic [16:0]        hix, hiy, mx, my, cx, cy;
  logic signed [17:0] dx, dy, adx_w, ady_w;
  side_t              s1_nxt;

  always_comb begin
    hix = {1'b0, rect_x} + {1'b0, rect_width};
    hiy = {1'b0, rect_y} + {1'b0, rect_height};
    mx  = ({1'b0, ball_x} < hix) ? {1'b0, ball_x} : hix;
    my  = ({1'b0, ball_y} < hiy) ? {1'b0, ball_y} : hiy;
    cx  = (mx > {1'b0, rect_x}) ? mx : {1'b0, rect_x};
    cy  = (my > {1'b0, rect_y}) ? my : {1'b0, rect_y};
    dx  = signed'({1'b0, cx}) - signed'({2'b00, ball_x});
    dy  = signed'({1'b0, cy}) - signed'({2'b00, ball_y});
    adx_w = dx[17] ? -dx : dx;
    ady_w = dy[17] ? -dy : dy;
    s1_nxt         = '0;
    s1_nxt.bx      = ball_x;
    s1_nxt.by      = ball_y;
    s1_nxt.vx      = vel_x;
    s1_nxt.vy      = vel_y;
    s1_nxt.dx_neg  = dx[17];
    s1_nxt.dx_pos  = !dx[17] && (dx != '0);
    s1_nxt.dy_neg  = dy[17];
    s1_nxt.dy_pos  = !dy[17] && (dy != '0);
    s1_nxt.r       = radius;
  end

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  side_t       s1_side_r, s2_side_r, s3_side_r;
  logic [15:0] s1_adx_r, s1_ady_r;
  logic [31:0] s2_sqx_r, s2_sqy_r;
  logic [23:0] s2_r2_r;
  logic [RW-1:0] s2_adx_r, s2_ady_r;
  logic [23:0] s3_d2_r, s3_qx_r, s3_qy_r;
  iter_t       s4_r;

  // stage 2 combinational: dominant axis
  side_t       s2_nxt;
  always_comb begin
    s2_nxt         = s1_side_r;
    s2_nxt.x_major = (s1_adx_r > s1_ady_r);
  end

  // stage 3 combinational
  logic [32:0] d2_w;
  side_t       s3_nxt;
  always_comb begin
    d2_w = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
    s3_nxt      = s2_side_r;
    s3_nxt.hit  = (d2_w <= {9'b0, s2_r2_r});
    s3_nxt.zero = (d2_w == '0);
  end

  // stage 4 combinational
  iter_t s4_nxt;
  logic [47:0] rqx, rqy;
  always_comb begin
    rqx = s3_qx_r * s3_qx_r;
    rqy = s3_qy_r * s3_qy_r;
    s4_nxt.side  = s3_side_r;
    s4_nxt.d2    = s3_d2_r;
    s4_nxt.lx.p  = PW'(s3_d2_r);
    s4_nxt.lx.a  = -(PW'(s3_d2_r));
    s4_nxt.lx.rhs = PW'({rqx, 2'b00});
    s4_nxt.lx.n  = '0;
    s4_nxt.ly.p  = PW'(s3_d2_r);
    s4_nxt.ly.a  = -(PW'(s3_d2_r));
    s4_nxt.ly.rhs = PW'({rqy, 2'b00});
    s4_nxt.ly.n  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_nxt;
      s1_adx_r  <= adx_w[15:0];
      s1_ady_r  <= ady_w[15:0];

      s2_side_r <= s2_nxt;
      s2_sqx_r  <= s1_adx_r * s1_adx_r;
      s2_sqy_r  <= s1_ady_r * s1_ady_r;
      s2_r2_r   <= s1_side_r.r * s1_side_r.r;
      s2_adx_r  <= s1_adx_r[RW-1:0];
      s2_ady_r  <= s1_ady_r[RW-1:0];

      // only a hit is used downstream, where d2 <= r^2 fits 24 bits
      s3_side_r <= s3_nxt;
      s3_d2_r   <= d2_w[23:0];
      s3_qx_r   <= s2_side_r.r * s2_adx_r;
      s3_qy_r   <= s2_side_r.r * s2_ady_r;

      s4_r      <= s4_nxt;
    end
  end

  assign v_o = s4_v_r;
  assign d_o = s4_r;

endmodule

// ===== rtl/crcr_root.sv =====
// Bit-serial search for both contact offsets, one bit per pipeline stage.
// Depends on crcr_pkg.
module crcr_root import crcr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_i,
  input  iter_t d_i,
  output logic  v_o,
  output iter_t d_o
);

  logic  v_r   [NSTEP];
  iter_t stg_r [NSTEP];

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    iter_t src;
    logic  src_v;
    iter_t stg_nxt;
    if (g == 0) begin : g_first
      assign src   = d_i;
      assign src_v = v_i;
    end else begin : g_next
      assign src   = stg_r[g-1];
      assign src_v = v_r[g-1];
    end

    always_comb begin
      stg_nxt    = src;
      stg_nxt.lx = lane_step(src.lx, src.d2, src.side.r, NSTEP - 1 - g);
      stg_nxt.ly = lane_step(src.ly, src.d2, src.side.r, NSTEP - 1 - g);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[g] <= stg_nxt;
      end
    end
  end

  assign v_o = v_r[NSTEP-1];
  assign d_o = stg_r[NSTEP-1];

endmodule

// ===== rtl/crcr_back.sv =====
// Final stage: contact point, normal, reflection, output register.
// Depends on crcr_pkg.
module crcr_back import crcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  iter_t              d_i,
  output logic               out_valid,
  output logic               hit,
  output logic [15:0]        contact_x,
  output logic [15:0]        contact_y,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_y,
  output logic signed [15:0] new_vel_x,
  output logic signed [15:0] new_vel_y
);

  function automatic logic signed [15:0] neg_sat(logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  function automatic logic [15:0] place(logic [15:0] c, logic [RW-1:0] o, logic neg);
    logic signed [17:0] so;
    logic signed [17:0] s;
    so = neg ? -signed'({6'b0, o}) : signed'({6'b0, o});
    s  = signed'({2'b00, c}) + so;
    if (s < 0) return 16'd0;
    if (s > 18'sd65535) return 16'hffff;
    return s[15:0];
  endfunction

  logic               out_valid_r, hit_r;
  logic [15:0]        cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [1:0]  nx_r, ny_r, nx_nxt, ny_nxt;
  logic signed [15:0] vx_r, vy_r, vx_nxt, vy_nxt;
  logic [RW-1:0]      ox, oy;
  side_t              s;

  always_comb begin
    s      = d_i.side;
    ox     = s.zero ? '0 : d_i.lx.n;
    oy     = s.zero ? '0 : d_i.ly.n;
    cx_nxt = '0;
    cy_nxt = '0;
    nx_nxt = '0;
    ny_nxt = '0;
    vx_nxt = s.vx;
    vy_nxt = s.vy;
    if (s.hit) begin
      cx_nxt = place(s.bx, ox, s.dx_neg);
      cy_nxt = place(s.by, oy, s.dy_neg);
      if (s.x_major) begin
        nx_nxt = s.dx_pos ? -2'sd1 : 2'sd1;
        if ((s.dx_pos && s.vx > 0) || (!s.dx_pos && s.vx < 0)) vx_nxt = neg_sat(s.vx);
      end else begin
        ny_nxt = s.dy_pos ? -2'sd1 : 2'sd1;
        if ((s.dy_pos && s.vy > 0) || (!s.dy_pos && s.vy < 0)) vy_nxt = neg_sat(s.vy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= s.hit;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign hit       = hit_r;
  assign contact_x = cx_r;
  assign contact_y = cy_r;
  assign normal_x  = nx_r;
  assign normal_y  = ny_r;
  assign new_vel_x = vx_r;
  assign new_vel_y = vy_r;

endmodule

// ===== rtl/crcr_checker.sv =====
// Port-level checks for circle_rect_collision_reflect, bound to the top.
// Depends on crcr_pkg.
module crcr_checker import crcr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic [15:0]        out_contact_x,
  input logic [15:0]        out_contact_y,
  input logic signed [1:0]  out_normal_x,
  input logic signed [1:0]  out_normal_y
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped during stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_contact_x == '0 && out_contact_y == '0 &&
                              out_normal_x == '0 && out_normal_y == '0)
    else $error("miss with nonzero contact or normal");

  a_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> ((out_normal_x != '0) != (out_normal_y != '0)) &&
                             out_normal_x != 2'b10 && out_normal_y != 2'b10)
    else $error("hit without a single axis normal");

endmodule

bind circle_rect_collision_reflect crcr_checker u_crcr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hit       (out_hit),
  .out_contact_x (out_contact_x),
  .out_contact_y (out_contact_y),
  .out_normal_x  (out_normal_x),
  .out_normal_y  (out_normal_y)
);

// ===== dv/circle_rect_collision_reflect_test.sv =====
// Self-checking testbench for circle_rect_collision_reflect: directed and random
// ball/rectangle pairs, radius changes while idle, random idling on both sides.
// Depends on crcr_pkg and the RTL of the block.
module circle_rect_collision_reflect_test import crcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]        bx;
    logic [15:0]        by;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        rx;
    logic [15:0]        ry;
    logic [15:0]        rw;
    logic [15:0]        rh;
  } shot_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic signed [1:0]  nx;
    logic signed [1:0]  ny;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } bounce_t;

  localparam int LATENCY = 18;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_ball_x = '0, in_ball_y = '0, in_rect_x = '0, in_rect_y = '0;
  logic [15:0] in_rect_width = '0, in_rect_height = '0;
  logic signed [15:0] in_vel_x = '0, in_vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [15:0] out_contact_x, out_contact_y;
  logic signed [1:0] out_normal_x, out_normal_y;
  logic signed [15:0] out_new_vel_x, out_new_vel_y;
  logic cfg_wr_en = 1'b0;
  logic [RW-1:0] cfg_wr_data = '0;

  shot_t   pending_shots[$];
  bounce_t expected_bounces[$];
  logic [RW-1:0] radius_model = RADIUS_RESET;
  int  mismatches = 0;
  bit  calm = 1'b0;     // no idling in the closing stretch
  int  in_idle = 0, out_idle = 0;

  always #6 clk = ~clk;

  circle_rect_collision_reflect i_dut (.*);

  // Nearest Q12.0 step of r*|d|/sqrt(d2), ties away from zero, capped at r.
  function automatic int unsigned contact_offset(int unsigned r, int unsigned ad,
                                                 longint unsigned d2);
    longint unsigned rhs, k;
    int unsigned n, t;
    rhs = 4 * longint'(r) * r * longint'(ad) * ad;
    n = 0;
    for (int b = 12; b >= 0; b--) begin
      t = n | (1 << b);
      k = 2 * longint'(t) - 1;
      if (t <= r && k * k * d2 <= rhs) n = t;
    end
    return n;
  endfunction

  function automatic logic signed [15:0] flip_vel(logic signed [15:0] v);
    return (v == -16'sd32768) ? 16'sd32767 : -v;
  endfunction

  function automatic bounce_t predict_bounce(shot_t s, logic [RW-1:0] rad);
    bounce_t o;
    int cx, cy, dx, dy, ox, oy;
    int unsigned adx, ady, r;
    longint unsigned d2;
    r  = rad;
    cx = (s.bx < int'(s.rx) + s.rw) ? s.bx : int'(s.rx) + s.rw;
    if (cx < s.rx) cx = s.rx;
    cy = (s.by < int'(s.ry) + s.rh) ? s.by : int'(s.ry) + s.rh;
    if (cy < s.ry) cy = s.ry;
    dx = cx - int'(s.bx);
    dy = cy - int'(s.by);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    d2 = longint'(adx) * adx + longint'(ady) * ady;
    o = '0;
    o.vx = s.vx;
    o.vy = s.vy;
    if (d2 <= longint'(r) * r) begin
      o.hit = 1'b1;
      ox = 0;
      oy = 0;
      if (d2 != 0) begin
        ox = contact_offset(r, adx, d2);
        oy = contact_offset(r, ady, d2);
        if (dx < 0) ox = -ox;
        if (dy < 0) oy = -oy;
      end
      ox = int'(s.bx) + ox;
      oy = int'(s.by) + oy;
      o.cx = ox < 0 ? 16'd0 : (ox > 65535 ? 16'hffff : ox[15:0]);
      o.cy = oy < 0 ? 16'd0 : (oy > 65535 ? 16'hffff : oy[15:0]);
      if (adx > ady) begin
        o.nx = dx > 0 ? -2'sd1 : 2'sd1;
        if ((o.nx < 0 && s.vx > 0) || (o.nx > 0 && s.vx < 0)) o.vx = flip_vel(s.vx);
      end else begin
        o.ny = dy > 0 ? -2'sd1 : 2'sd1;
        if ((o.ny < 0 && s.vy > 0) || (o.ny > 0 && s.vy < 0)) o.vy = flip_vel(s.vy);
      end
    end
    return o;
  endfunction

  // Driver: presents the head of the queue, holds it until the transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_bounces.push_back(predict_bounce(
          {in_ball_x, in_ball_y, in_vel_x, in_vel_y,
           in_rect_x, in_rect_y, in_rect_width, in_rect_height}, radius_model));
      end
      if (!in_valid || in_ready) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          in_idle <= $urandom_range(1, 17);
          in_valid <= 1'b0;
        end else if (pending_shots.size() > 0) begin
          shot_t s;
          s = pending_shots.pop_front();
          {in_ball_x, in_ball_y, in_vel_x, in_vel_y,
           in_rect_x, in_rect_y, in_rect_width, in_rect_height} <= s;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        bounce_t got, want;
        got = {out_hit, out_contact_x, out_contact_y, out_normal_x, out_normal_y,
               out_new_vel_x, out_new_vel_y};
        if (expected_bounces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %p", got);
        end else begin
          want = expected_bounces.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      // receiver stalls in bursts
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        out_idle <= $urandom_range(1, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic shot_t random_shot(bit near);
    shot_t s;
    s.vx = $urandom;
    s.vy = $urandom;
    if (!near) begin
      s.bx = $urandom; s.by = $urandom; s.rx = $urandom; s.ry = $urandom;
      s.rw = $urandom; s.rh = $urandom;
    end else begin
      // small rectangle with the ball just around it, so hits are common
      s.rw = $urandom_range(0, 3000);
      s.rh = $urandom_range(0, 3000);
      s.rx = $urandom_range(0, 65535 - s.rw);
      s.ry = $urandom_range(0, 65535 - s.rh);
      s.bx = 16'(int'(s.rx) + $urandom_range(0, s.rw + 9000) - 4500);
      s.by = 16'(int'(s.ry) + $urandom_range(0, s.rh + 9000) - 4500);
    end
    return s;
  endfunction

  task automatic run_phase(logic [RW-1:0] rad, int count);
    // drain until the pipe is empty, let the latency pass, then load the radius
    wait (pending_shots.size() == 0 && !in_valid && expected_bounces.size() == 0);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_wr_data <= rad;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_model = rad;
    for (int i = 0; i < count; i++) pending_shots.push_back(random_shot($urandom_range(0, 3) != 0));
  endtask

  initial begin
    shot_t s;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset radius, extremes, inside, each side, corners, saturation
    pending_shots.push_back('{16'd1000, 16'd1000, 16'sd256, -16'sd32768, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd0, 16'd0, 16'sd100, 16'sd100, 16'd0, 16'd0, 16'd0, 16'd0});
    pending_shots.push_back('{16'hffff, 16'hffff, 16'sd32767, -16'sd32768, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
    pending_shots.push_back('{16'd800, 16'd1000, 16'sd300, -16'sd5, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd1200, 16'd1000, -16'sd32768, 16'sd5, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd1000, 16'd800, 16'sd7, 16'sd32767, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd1000, 16'd1200, 16'sd7, -16'sd32768, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd820, 16'd820, 16'sd1, 16'sd1, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd1180, 16'd1180, -16'sd1, -16'sd1, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd500, 16'd1000, 16'sd50, 16'sd50, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd10, 16'd10, -16'sd1, -16'sd1, 16'd100, 16'd0, 16'd10, 16'd10});
    pending_shots.push_back('{16'hfff0, 16'hfff0, 16'sd0, 16'sd0, 16'd0, 16'd0, 16'hffe0, 16'hffe0});
    pending_shots.push_back('{16'd772, 16'd1000, 16'sd3, 16'sd0, 16'd900, 16'd900, 16'd200, 16'd200});
    pending_shots.push_back('{16'd771, 16'd1000, 16'sd3, 16'sd0, 16'd900, 16'd900, 16'd200, 16'd200});
    run_phase(12'd1, 12);
    pending_shots.push_back('{16'd899, 16'd1000, 16'sd3, 16'sd3, 16'd900, 16'd900, 16'd200, 16'd200});
    run_phase(12'd4095, 300);
    s = '{16'd100, 16'd100, 16'sd5, 16'sd5, 16'd3000, 16'd3000, 16'd10, 16'd10};
    pending_shots.push_back(s);
    run_phase(12'd37, 300);
    run_phase(12'd2000, 300);
    run_phase($urandom_range(1, 4095), 300);
    run_phase(RADIUS_RESET, 150);
    wait (pending_shots.size() == 0);
    calm = 1'b1;
    for (int i = 0; i < 150; i++) pending_shots.push_back(random_shot(1'b1));
    wait (pending_shots.size() == 0 && !in_valid && expected_bounces.size() == 0);
    repeat (LATENCY + 2) @(posedge clk);
    if (mismatches == 0 && expected_bounces.size() == 0)
      $display("circle_rect_collision_reflect verification clean");
    else
      $display("circle_rect_collision_reflect verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("circle_rect_collision_reflect verification failed");
    $finish;
  end

endmodule
